>>> rtl/cnls_pkg.sv
// Package for the CAN node liveness supervisor: sizes, codes, seat table
// entry layout and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package cnls_pkg;

  localparam int SEATS   = 16;
  localparam int SEAT_IW = (SEATS > 1) ? $clog2(SEATS) : 1;

  localparam int ID_W    = 11;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 16;
  localparam int TXCD_W  = 8;
  localparam int PADDR_W = 5;

  localparam logic [BYTE_W-1:0] HB_BYTE1 = 8'h01;
  localparam logic [BYTE_W-1:0] HB_BYTE2 = 8'h55;
  localparam logic [CNT_W-1:0]  CNT_MAX  = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_TICK  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_HB_BASE     = 3'd0,
    REG_NM_ID       = 3'd1,
    REG_STATUS_ID   = 3'd2,
    REG_TX_PERIOD   = 3'd3,
    REG_NM_TIMEOUT  = 3'd4,
    REG_ST_TIMEOUT  = 3'd5,
    REG_SEAT_TIMEOUT = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [ID_W-1:0]   hb_base;
    logic [ID_W-1:0]   nm_id;
    logic [ID_W-1:0]   status_id;
    logic [TXCD_W-1:0] tx_period;
    logic [CNT_W-1:0]  nm_timeout;
    logic [CNT_W-1:0]  status_timeout;
    logic [CNT_W-1:0]  seat_timeout;
  } cfg_t;

  typedef struct packed {
    logic             seen;
    logic [CNT_W-1:0] silence;
    logic [ID_W-1:0]  shown;
  } seat_entry_t;

  typedef enum logic [1:0] {
    ADDR_FRAME = 2'd0,
    ADDR_QUERY = 2'd1,
    ADDR_WALK  = 2'd2
  } addr_sel_t;

  typedef struct packed {
    logic      capture;
    addr_sel_t addr_sel;
    logic      rd_en;
    logic      frame_rd;
    logic      frame_wr;
    logic      tick_head;
    logic      walk_wr;
    logic      walk_clr;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_last;
  } dp_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

>>> rtl/cnls_ctrl.sv
// Controller of the liveness supervisor: sequences frame, tick and query
// items and owns the input and output handshakes. Uses cnls_pkg.
`default_nettype none
module cnls_ctrl import cnls_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] opcode,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_FRAME_RD  = 8'b0000_0010,
    S_FRAME_WR  = 8'b0000_0100,
    S_QUERY_RD  = 8'b0000_1000,
    S_TICK_HEAD = 8'b0001_0000,
    S_WALK_RD   = 8'b0010_0000,
    S_WALK_WR   = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // The output register can take a new beat when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.addr_sel = ADDR_WALK;
    unique case (state)
      S_IDLE: begin
        cmd.capture = accept;
        if (accept) begin
          unique case (op_t'(opcode))
            OP_FRAME: state_next = S_FRAME_RD;
            OP_TICK:  state_next = S_TICK_HEAD;
            OP_QUERY: state_next = S_QUERY_RD;
            OP_NONE:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_FRAME_RD: begin
        cmd.addr_sel = ADDR_FRAME;
        cmd.rd_en    = 1'b1;
        cmd.frame_rd = 1'b1;
        state_next   = S_FRAME_WR;
      end
      S_FRAME_WR: begin
        cmd.addr_sel = ADDR_FRAME;
        cmd.frame_wr = 1'b1;
        state_next   = S_DONE;
      end
      S_QUERY_RD: begin
        cmd.addr_sel = ADDR_QUERY;
        cmd.rd_en    = 1'b1;
        state_next   = S_DONE;
      end
      S_TICK_HEAD: begin
        cmd.tick_head = 1'b1;
        cmd.walk_clr  = 1'b1;
        state_next    = S_WALK_RD;
      end
      S_WALK_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_WALK_WR;
      end
      S_WALK_WR: begin
        cmd.walk_wr = 1'b1;
        state_next  = status.walk_last ? S_DONE : S_WALK_RD;
      end
      S_DONE: begin
        cmd.out_load = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/cnls_dp.sv
// Datapath of the liveness supervisor: item registers, send countdown,
// watched-message counters, seat table memory and result register. Uses cnls_pkg.
`default_nettype none
module cnls_dp import cnls_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire dp_cmd_t           cmd,
  output dp_status_t             status,
  input  wire logic [1:0]        opcode,
  input  wire logic [ID_W-1:0]   msg_id,
  input  wire logic [BYTE_W-1:0] rx_byte1,
  input  wire logic [BYTE_W-1:0] rx_byte2,
  input  wire logic [5:0]        seat_index,
  output logic                   send_heartbeat,
  output logic                   nm_received,
  output logic                   status_received,
  output logic                   nm_timed_out,
  output logic                   status_timed_out,
  output logic [ID_W-1:0]        seat_display_id,
  output logic                   seat_out_of_range
);

  // Captured item.
  op_t               op_q;
  logic [ID_W-1:0]   id_q;
  logic [BYTE_W-1:0] b1_q;
  logic [BYTE_W-1:0] b2_q;
  logic [5:0]        si_q;

  // Tick state.
  logic [TXCD_W-1:0] tx_countdown;
  logic              nm_pending, st_pending;
  logic [CNT_W-1:0]  nm_silence, st_silence;
  logic              res_send, res_nm_rx, res_st_rx, res_nm_to, res_st_to;

  // Seat table.
  seat_entry_t       mem [SEATS];
  logic [SEATS-1:0]  seat_valid;
  seat_entry_t       rd_q;
  logic              rd_valid_q;
  logic [SEAT_IW-1:0] addr;
  logic [SEAT_IW-1:0] walk_cnt;
  logic              mem_we;
  seat_entry_t       wdata;
  seat_entry_t       rd_entry;

  logic              hb_match;
  logic [ID_W-1:0]   seat_diff;
  logic              frame_in_range;
  logic              query_in_range;
  logic              frame_oor;

  logic [TXCD_W-1:0] cd_reload;
  logic [TXCD_W-1:0] cd_next;
  logic [CNT_W-1:0]  nm_sil_next, st_sil_next;
  logic [CNT_W-1:0]  seat_sil_next;

  assign hb_match = ((id_q & cfg.hb_base) == cfg.hb_base) &&
                    (b1_q == HB_BYTE1) && (b2_q == HB_BYTE2);
  // No wrap: a heartbeat match implies id_q >= hb_base.
  assign seat_diff      = id_q - cfg.hb_base;
  assign frame_in_range = (seat_diff < ID_W'(SEATS));
  assign query_in_range = ({1'b0, si_q} < 7'(SEATS));
  assign frame_oor      = hb_match && !frame_in_range;

  assign status.walk_last = (walk_cnt == SEAT_IW'(SEATS - 1));
  assign rd_entry = rd_valid_q ? rd_q : '0;

  always_comb begin
    case (cmd.addr_sel)
      ADDR_FRAME: addr = seat_diff[SEAT_IW-1:0];
      ADDR_QUERY: addr = si_q[SEAT_IW-1:0];
      default:    addr = walk_cnt;
    endcase
  end

  always_comb begin
    wdata         = rd_entry;
    mem_we        = 1'b0;
    seat_sil_next = sat_inc(rd_entry.silence);
    if (cmd.frame_wr) begin
      mem_we      = hb_match && frame_in_range;
      wdata.seen  = 1'b1;
      wdata.shown = id_q;
    end else if (cmd.walk_wr) begin
      mem_we = 1'b1;
      if (rd_entry.seen) begin
        wdata.seen    = 1'b0;
        wdata.silence = '0;
      end else begin
        wdata.silence = seat_sil_next;
      end
      if (wdata.silence >= cfg.seat_timeout) begin
        wdata.shown = '0;
      end
    end
  end

  // Send countdown: reload on zero, then count down.
  always_comb begin
    cd_reload = (tx_countdown == '0) ? cfg.tx_period : tx_countdown;
    cd_next   = (cd_reload != '0) ? cd_reload - TXCD_W'(1) : cd_reload;
  end

  assign nm_sil_next = sat_inc(nm_pending ? '0 : nm_silence);
  assign st_sil_next = sat_inc(st_pending ? '0 : st_silence);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= op_t'(opcode);
      id_q <= msg_id;
      b1_q <= rx_byte1;
      b2_q <= rx_byte2;
      si_q <= seat_index;
    end
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[addr];
    end
    if (cmd.walk_clr) begin
      walk_cnt <= '0;
    end else if (cmd.walk_wr) begin
      walk_cnt <= walk_cnt + SEAT_IW'(1);
    end
    if (cmd.out_load) begin
      send_heartbeat    <= (op_q == OP_TICK) && res_send;
      nm_received       <= (op_q == OP_TICK) && res_nm_rx;
      status_received   <= (op_q == OP_TICK) && res_st_rx;
      nm_timed_out      <= (op_q == OP_TICK) && res_nm_to;
      status_timed_out  <= (op_q == OP_TICK) && res_st_to;
      seat_display_id   <= (op_q == OP_QUERY && query_in_range) ? rd_entry.shown : '0;
      seat_out_of_range <= ((op_q == OP_FRAME) && frame_oor) ||
                           ((op_q == OP_QUERY) && !query_in_range);
    end
    if (cmd.tick_head) begin
      res_send  <= (tx_countdown == '0);
      res_nm_rx <= nm_pending;
      res_st_rx <= st_pending;
      res_nm_to <= (nm_sil_next >= cfg.nm_timeout);
      res_st_to <= (st_sil_next >= cfg.status_timeout);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_countdown <= '0;
      nm_pending   <= 1'b0;
      st_pending   <= 1'b0;
      nm_silence   <= '0;
      st_silence   <= '0;
      seat_valid   <= '0;
      rd_valid_q   <= 1'b0;
    end else begin
      if (mem_we) begin
        seat_valid[addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid_q <= seat_valid[addr];
      end
      if (cmd.frame_rd) begin
        if (id_q == cfg.nm_id) begin
          nm_pending <= 1'b1;
        end
        if (id_q == cfg.status_id) begin
          st_pending <= 1'b1;
        end
      end
      if (cmd.tick_head) begin
        tx_countdown <= cd_next;
        nm_pending   <= 1'b0;
        st_pending   <= 1'b0;
        nm_silence   <= nm_sil_next;
        st_silence   <= st_sil_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/can_node_liveness_supervisor_top.sv
// Top level of the CAN node liveness supervisor: configuration registers on
// an APB-style port, controller and datapath. Uses cnls_pkg, cnls_ctrl, cnls_dp.
// From accept to out_valid a frame passes S_FRAME_RD, S_FRAME_WR and S_DONE, a query
// S_QUERY_RD and S_DONE, a tick S_TICK_HEAD, then S_WALK_RD and S_WALK_WR for each
// seat (a read and a write through the table's single port) and S_DONE.
// A new item is accepted in the cycle after its predecessor's result is loaded;
// opcode 3 leaves the controller idle and gives no result.
// Reset (rst, synchronous) clears the send countdown, silence counters, pending flags
// and seat valid bits and loads the register defaults; no clearing pass is needed.
`default_nettype none
module can_node_liveness_supervisor_top import cnls_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         opcode,
  input  wire logic [ID_W-1:0]    msg_id,
  input  wire logic [BYTE_W-1:0]  rx_byte1,
  input  wire logic [BYTE_W-1:0]  rx_byte2,
  input  wire logic [5:0]         seat_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    send_heartbeat,
  output logic                    nm_received,
  output logic                    status_received,
  output logic                    nm_timed_out,
  output logic                    status_timed_out,
  output logic [ID_W-1:0]         seat_display_id,
  output logic                    seat_out_of_range
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  reg_idx_t   reg_idx;
  logic       cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hb_base        <= ID_W'(512);
      cfg.nm_id          <= ID_W'(1024);
      cfg.status_id      <= '0;
      cfg.tx_period      <= TXCD_W'(200);
      cfg.nm_timeout     <= CNT_W'(250);
      cfg.status_timeout <= CNT_W'(50);
      cfg.seat_timeout   <= CNT_W'(1000);
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_HB_BASE:      cfg.hb_base        <= pwdata[ID_W-1:0];
        REG_NM_ID:        cfg.nm_id          <= pwdata[ID_W-1:0];
        REG_STATUS_ID:    cfg.status_id      <= pwdata[ID_W-1:0];
        REG_TX_PERIOD:    cfg.tx_period      <= pwdata[TXCD_W-1:0];
        REG_NM_TIMEOUT:   cfg.nm_timeout     <= pwdata[CNT_W-1:0];
        REG_ST_TIMEOUT:   cfg.status_timeout <= pwdata[CNT_W-1:0];
        REG_SEAT_TIMEOUT: cfg.seat_timeout   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HB_BASE:      prdata = {21'd0, cfg.hb_base};
      REG_NM_ID:        prdata = {21'd0, cfg.nm_id};
      REG_STATUS_ID:    prdata = {21'd0, cfg.status_id};
      REG_TX_PERIOD:    prdata = {24'd0, cfg.tx_period};
      REG_NM_TIMEOUT:   prdata = {16'd0, cfg.nm_timeout};
      REG_ST_TIMEOUT:   prdata = {16'd0, cfg.status_timeout};
      REG_SEAT_TIMEOUT: prdata = {16'd0, cfg.seat_timeout};
      default:          prdata = '0;
    endcase
  end

  cnls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  cnls_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cmd               (cmd),
    .status            (status),
    .opcode            (opcode),
    .msg_id            (msg_id),
    .rx_byte1          (rx_byte1),
    .rx_byte2          (rx_byte2),
    .seat_index        (seat_index),
    .send_heartbeat    (send_heartbeat),
    .nm_received       (nm_received),
    .status_received   (status_received),
    .nm_timed_out      (nm_timed_out),
    .status_timed_out  (status_timed_out),
    .seat_display_id   (seat_display_id),
    .seat_out_of_range (seat_out_of_range)
  );

endmodule
`default_nettype wire
